@@ sv/wsfd_pkg.sv @@
// Shared types and constants of the WebSocket frame deframer.
// Depends on nothing; used by every module of the deframer.
package wsfd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned OpcodeW    = 4;
  localparam int unsigned LengthW    = 64;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned OutTdataW  = 80;

  // 7-bit length codes that announce an extended length field.
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  // Number of extended length bytes that follow each code.
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic                 fin;
    logic [OpcodeW-1:0]   opcode;
    logic                 masked;
    logic [LengthW-1:0]   frame_len;
    logic [ByteW-1:0]     data_byte;
    logic                 last;
  } result_t;

endpackage

@@ sv/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer (receive side of the frame format).
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_buf.
//
// The deframer takes a received byte stream, one byte per transaction, and
// splits it into frames one after another. It reads FIN and the opcode from
// the first header byte, the mask bit and the 7-bit length from the second,
// then an optional 2-byte or 8-byte big-endian extended length and an optional
// 4-byte masking key. When the header is complete it emits one header
// transaction (tuser low, tdata carrying FIN, opcode, mask flag and length),
// then one transaction per payload byte (tuser high) with the byte unmasked;
// tlast marks the final transaction of a frame, and a zero-length frame's
// header transaction carries tlast itself. Header bytes that do not complete
// the header produce nothing. RSV bits are ignored and the top bit of a 64-bit
// length is not checked. One byte may be accepted on every clock edge while the
// output buffer has room, so the rate is set only by the result side.
// A two-entry output buffer (output register plus skid register) lets input
// keep flowing while a result waits, and s_axis_tready_o drops only when both
// entries are occupied. When the output is free, the result of an accepted byte
// is registered into the output register and offered in the cycle after.
module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [7:0] stream_byte
  input  logic [ByteW-1:0]     s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [0] fin, [4:1] opcode, [5] masked, [69:6] frame_len,
  // [77:70] data_byte, [79:78] zero
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // [0] kind: 0 header, 1 payload byte
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  logic    in_fire;
  logic    res_valid;
  result_t res;
  logic    buf_ready;

  // A byte is consumed only when the output buffer has room for its result.
  assign s_axis_tready_o = buf_ready;
  assign in_fire         = s_axis_tvalid_i && buf_ready;

  wsfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_fire),
    .byte_i       (s_axis_tdata_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsfd_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (in_fire && res_valid),
    .res_i           (res),
    .ready_o         (buf_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ sv/wsfd_parser.sv @@
// Frame header parser and payload unmasking for the deframer.
// Depends on wsfd_pkg; produces at most one result per accepted byte.
module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e               phase_q, phase_d;
  logic                 fin_q, fin_d;
  logic [OpcodeW-1:0]   opcode_q, opcode_d;
  logic                 mask_q, mask_d;
  logic [LengthW-1:0]   length_q, length_d;
  logic [3:0]           len_left_q, len_left_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [2:0]           key_seen_q, key_seen_d;
  logic [LengthW-1:0]   pay_left_q, pay_left_d;
  logic [1:0]           key_idx_q, key_idx_d;

  logic [6:0]           len7;
  logic [3:0]           len_left_dec;
  logic [2:0]           key_seen_inc;
  logic [LengthW-1:0]   len_ext;
  logic [LengthW-1:0]   pay_left_dec;
  logic                 len_empty;
  logic [ByteW-1:0]     key_byte;

  assign len7         = byte_i[6:0];
  assign len_left_dec = len_left_q - 4'd1;
  assign key_seen_inc = key_seen_q + 3'd1;
  assign len_ext      = {length_q[LengthW-ByteW-1:0], byte_i};
  assign pay_left_dec = pay_left_q - {{(LengthW-1){1'b0}}, 1'b1};
  assign len_empty    = (length_d == '0);

  always_comb begin
    case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_SECOND: begin
        if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
          phase_d = PH_EXTLEN;
        end else if (byte_i[7]) begin
          phase_d = PH_KEY;
        end else begin
          phase_d = len_empty ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_EXTLEN: begin
        if (len_left_dec == '0) begin
          if (mask_q) begin
            phase_d = PH_KEY;
          end else begin
            phase_d = len_empty ? PH_FIRST : PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        if (key_seen_inc[2]) begin
          phase_d = len_empty ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pay_left_dec == '0) begin
          phase_d = PH_FIRST;
        end
      end
      default: begin
        phase_d = PH_SECOND;
      end
    endcase
  end

  // Held fields and the result of this byte.
  always_comb begin
    fin_d       = fin_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    length_d    = length_q;
    len_left_d  = len_left_q;
    key_d       = key_q;
    key_seen_d  = key_seen_q;
    pay_left_d  = pay_left_q;
    key_idx_d   = key_idx_q;
    res_valid_o = 1'b0;
    res_o.kind      = KIND_HEADER;
    res_o.data_byte = '0;
    res_o.last      = 1'b0;
    case (phase_q)
      PH_SECOND: begin
        mask_d = byte_i[7];
        if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
          length_d   = '0;
          len_left_d = (len7 == Len7Ext16) ? ExtBytes16 : ExtBytes64;
        end else begin
          length_d = {{(LengthW-7){1'b0}}, len7};
          if (byte_i[7]) begin
            key_d      = '0;
            key_seen_d = '0;
          end else begin
            res_valid_o = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        length_d   = len_ext;
        len_left_d = len_left_dec;
        if (len_left_dec == '0) begin
          if (mask_q) begin
            key_d      = '0;
            key_seen_d = '0;
          end else begin
            res_valid_o = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_d      = {key_q[KeyW-ByteW-1:0], byte_i};
        key_seen_d = key_seen_inc;
        res_valid_o = key_seen_inc[2];
      end
      PH_PAYLOAD: begin
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_PAYLOAD;
        res_o.data_byte = mask_q ? (byte_i ^ key_byte) : byte_i;
        res_o.last      = (pay_left_dec == '0);
        key_idx_d       = key_idx_q + 2'd1;
        pay_left_d      = pay_left_dec;
      end
      default: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[OpcodeW-1:0];
      end
    endcase
    // A completed header sets up the payload count and key position.
    if (res_valid_o && res_o.kind == KIND_HEADER) begin
      res_o.last = len_empty;
      pay_left_d = length_d;
      key_idx_d  = '0;
    end
    res_o.fin       = fin_d;
    res_o.opcode    = opcode_d;
    res_o.masked    = mask_d;
    res_o.frame_len = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      fin_q      <= 1'b0;
      opcode_q   <= '0;
      mask_q     <= 1'b0;
      length_q   <= '0;
      len_left_q <= '0;
      key_q      <= '0;
      key_seen_q <= '0;
      pay_left_q <= '0;
      key_idx_q  <= '0;
    end else if (byte_valid_i) begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      opcode_q   <= opcode_d;
      mask_q     <= mask_d;
      length_q   <= length_d;
      len_left_q <= len_left_d;
      key_q      <= key_d;
      key_seen_q <= key_seen_d;
      pay_left_q <= pay_left_d;
      key_idx_q  <= key_idx_d;
    end
  end

endmodule

@@ sv/wsfd_out_buf.sv @@
// Output register with a skid stage for the deframer's result stream.
// Depends on wsfd_pkg for the result type and the packed data width.
module wsfd_out_buf
  import wsfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  result_t              res_i,
  output logic                 ready_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_valid_q && m_axis_tready_i;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= res_i;
      end else begin
        main_q <= res_i;
      end
    end
  end

  assign m_axis_tvalid_o = main_valid_q;
  assign m_axis_tuser_o  = main_q.kind;
  assign m_axis_tlast_o  = main_q.last;
  assign m_axis_tdata_o  = {2'b00, main_q.data_byte, main_q.frame_len,
                            main_q.masked, main_q.opcode, main_q.fin};

endmodule

@@ bench/websocket_frame_deframer_test.sv @@
// Self-checking bench for the WebSocket frame deframer: random frames in, results checked.
// Depends on wsfd_pkg and websocket_frame_deframer, which brings in wsfd_parser and wsfd_out_buf.
module websocket_frame_deframer_test;
  import wsfd_pkg::*;

  localparam int unsigned ResetCycles = 7;
  localparam int unsigned ItemTarget  = 1150;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned LongHoldOff = 400;
  localparam int unsigned HoldOffAt   = 200;

  // How the payload length of a generated frame is encoded in its header.
  typedef enum logic [1:0] {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_e;

  typedef struct {
    kind_e              kind;
    logic               fin;
    logic [OpcodeW-1:0] opcode;
    logic               masked;
    logic [LengthW-1:0] length;
    logic [ByteW-1:0]   data;
    logic               last;
  } frame_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ByteW-1:0]     s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  logic [ByteW-1:0] bytes_to_send[$];
  frame_result_t    awaited_results[$];

  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // Own copy of the parser state, advanced once per accepted input byte.
  phase_e             frame_phase = PH_FIRST;
  logic               fin_q = 1'b0;
  logic [OpcodeW-1:0] opcode_q = '0;
  logic               mask_q = 1'b0;
  logic [LengthW-1:0] length_q = '0;
  logic [3:0]         ext_left_q = '0;
  logic [KeyW-1:0]    key_q = '0;
  logic [2:0]         key_count_q = '0;
  logic [LengthW-1:0] payload_left_q = '0;
  logic [1:0]         key_pos_q = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  websocket_frame_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  task automatic push_result(input kind_e k, input logic [ByteW-1:0] d, input logic l);
    frame_result_t r;
    r.kind   = k;
    r.fin    = fin_q;
    r.opcode = opcode_q;
    r.masked = mask_q;
    r.length = length_q;
    r.data   = d;
    r.last   = l;
    awaited_results.push_back(r);
  endtask

  task automatic header_complete();
    push_result(KIND_HEADER, '0, length_q == '0);
    payload_left_q = length_q;
    key_pos_q      = '0;
    frame_phase    = (length_q == '0) ? PH_FIRST : PH_PAYLOAD;
  endtask

  // The length is known; a masked frame still has its key to come.
  task automatic length_known();
    if (mask_q) begin
      key_count_q = '0;
      key_q       = '0;
      frame_phase = PH_KEY;
    end else begin
      header_complete();
    end
  endtask

  task automatic deframe_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] d;
    case (frame_phase)
      PH_SECOND: begin
        mask_q = b[7];
        if (b[6:0] == Len7Ext16) begin
          length_q    = '0;
          ext_left_q  = ExtBytes16;
          frame_phase = PH_EXTLEN;
        end else if (b[6:0] == Len7Ext64) begin
          length_q    = '0;
          ext_left_q  = ExtBytes64;
          frame_phase = PH_EXTLEN;
        end else begin
          length_q = {57'd0, b[6:0]};
          length_known();
        end
      end
      PH_EXTLEN: begin
        length_q   = {length_q[LengthW-9:0], b};
        ext_left_q = ext_left_q - 4'd1;
        if (ext_left_q == '0) length_known();
      end
      PH_KEY: begin
        key_q       = {key_q[KeyW-9:0], b};
        key_count_q = key_count_q + 3'd1;
        if (key_count_q >= 3'd4) header_complete();
      end
      PH_PAYLOAD: begin
        d = b;
        if (mask_q) d = d ^ key_q[(3 - key_pos_q) * 8 +: 8];
        key_pos_q      = key_pos_q + 2'd1;
        payload_left_q = payload_left_q - 64'd1;
        push_result(KIND_PAYLOAD, d, payload_left_q == '0);
        if (payload_left_q == '0) frame_phase = PH_FIRST;
      end
      default: begin
        // Phase codes that are never entered behave like the first header byte.
        fin_q       = b[7];
        opcode_q    = b[3:0];
        frame_phase = PH_SECOND;
      end
    endcase
  endtask

  // Queues one frame. Only send_len payload bytes are queued, so a frame may be left open.
  task automatic queue_frame(input logic [ByteW-1:0] first, input logic msk,
                             input len_form_e form, input logic [LengthW-1:0] len,
                             input longint unsigned send_len);
    logic [KeyW-1:0] key;
    key = $urandom;
    bytes_to_send.push_back(first);
    case (form)
      FORM_EXT16: begin
        bytes_to_send.push_back({msk, Len7Ext16});
        bytes_to_send.push_back(len[15:8]);
        bytes_to_send.push_back(len[7:0]);
      end
      FORM_EXT64: begin
        bytes_to_send.push_back({msk, Len7Ext64});
        for (int i = 7; i >= 0; i--) bytes_to_send.push_back(len[i*8 +: 8]);
      end
      default: bytes_to_send.push_back({msk, len[6:0]});
    endcase
    if (msk) begin
      for (int i = 3; i >= 0; i--) bytes_to_send.push_back(key[i*8 +: 8]);
    end
    for (longint unsigned i = 0; i < send_len; i++) bytes_to_send.push_back(8'($urandom));
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: offers queued bytes, holding each until the transaction completes.
  int unsigned tx_gap = 0;
  int unsigned tx_mode_left = 0;
  logic        tx_quiet = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (s_tvalid && !s_tready) begin
        // Byte still on offer; keep it stable.
      end else if (tx_gap != 0) begin
        s_tvalid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (bytes_to_send.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= bytes_to_send.pop_front();
        tx_gap   <= tx_quiet ? 0 : pick_gap();
        if (tx_mode_left == 0) begin
          tx_mode_left <= $urandom_range(20, 120);
          tx_quiet     <= ~tx_quiet;
        end else begin
          tx_mode_left <= tx_mode_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off that fills the block.
  int unsigned rx_stall = 0;
  int unsigned rx_mode_left = 0;
  logic        rx_quiet = 1'b0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (!long_hold_done && results_seen >= HoldOffAt) begin
      m_tready       <= 1'b0;
      rx_stall       <= LongHoldOff;
      long_hold_done <= 1'b1;
    end else if (rx_stall != 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
      rx_stall <= rx_quiet ? 0 : pick_gap();
      if (rx_mode_left == 0) begin
        rx_mode_left <= $urandom_range(30, 150);
        rx_quiet     <= ~rx_quiet;
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    frame_result_t want;
    if (!rst_ni) begin
      results_seen <= 0;
      mismatches   <= 0;
    end else if (m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        if (mismatches < MaxReports)
          $display("unexpected result: user %0d tdata %h last %0d",
                   m_tuser, m_tdata, m_tlast);
        mismatches <= mismatches + 1;
      end else begin
        want = awaited_results.pop_front();
        if (m_tuser !== want.kind || m_tdata[0] !== want.fin ||
            m_tdata[4:1] !== want.opcode || m_tdata[5] !== want.masked ||
            m_tdata[69:6] !== want.length || m_tdata[77:70] !== want.data ||
            m_tdata[79:78] !== 2'b00 || m_tlast !== want.last) begin
          if (mismatches < MaxReports) begin
            $display("mismatch: expected kind %0d fin %0d op %h mask %0d len %h data %h last %0d",
                     want.kind, want.fin, want.opcode, want.masked, want.length,
                     want.data, want.last);
            $display("          got kind %0d fin %0d op %h mask %0d len %h data %h pad %b last %0d",
                     m_tuser, m_tdata[0], m_tdata[4:1], m_tdata[5], m_tdata[69:6],
                     m_tdata[77:70], m_tdata[79:78], m_tlast);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Counts cycles in which neither side completes a transaction.
  always @(posedge clk_i or negedge rst_ni) begin : idle_watch
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_control
    logic [ByteW-1:0]   first;
    logic               msk;
    logic [LengthW-1:0] len;
    len_form_e          form;
    int unsigned        roll;

    // Directed frames: empty frames both plain and masked with extreme opcodes and RSV bits,
    // a one-byte masked frame, an empty frame via the 16-bit length and a 64-bit length.
    queue_frame(8'h8F, 1'b0, FORM_SHORT, 64'd0, 0);
    queue_frame(8'h70, 1'b1, FORM_SHORT, 64'd0, 0);
    queue_frame(8'hF1, 1'b1, FORM_SHORT, 64'd1, 1);
    queue_frame(8'h09, 1'b0, FORM_EXT16, 64'd0, 0);
    queue_frame(8'h82, 1'b0, FORM_EXT64, 64'd1, 1);

    // Random well-formed frames; header bytes are fully random, RSV bits included.
    while (bytes_to_send.size() < ItemTarget) begin
      first = 8'($urandom);
      msk   = ($urandom_range(0, 99) < 60);
      roll  = $urandom_range(0, 99);
      if (roll < 50) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(0, 12));
      end else if (roll < 65) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(13, 125));
      end else if (roll < 85) begin
        form = FORM_EXT16;
        len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(300, 700))
                                           : 64'($urandom_range(0, 200));
      end else begin
        form = FORM_EXT64;
        len  = 64'($urandom_range(0, 40));
      end
      queue_frame(first, msk, form, len, len);
    end

    // A length with its top bit set is taken as it stands: the frame stays open to the end.
    queue_frame(8'h81, 1'b1, FORM_EXT64, 64'h8000_0000_0000_0003, 12);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((bytes_to_send.size() != 0 || s_tvalid || awaited_results.size() != 0) &&
           idle_cycles < IdleLimit)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (idle_cycles < IdleLimit && mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
